// File: rtl/pec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pec_pkg
// Shared types, constants and helper functions of the periodic event counter.
// ----------------------------------------------------------------------------
package pec_pkg;

	localparam int COUNT_BITS_DEFAULT = 32;
	localparam int TIME_BITS = 64;
	localparam int PERIOD_BITS = 48;
	localparam int VALUE_BITS = 32;
	localparam int KIND_BITS = 2;
	localparam int CFG_INDEX_BITS = 2;
	localparam int DIV_STEPS = TIME_BITS;
	localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

	localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_START = 2'd1;

	localparam logic [KIND_BITS-1:0] KIND_FULL = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_TRUNC = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_SKIP = 2'd2;

	localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 48'd1000000000;
	localparam logic [TIME_BITS-1:0] START_RESET = 64'd0;
	localparam logic [TIME_BITS-1:0] DEADLINE_RESET = 64'd1000000000;

	typedef struct packed {
		logic                 op;
		logic [TIME_BITS-1:0] timestamp_ns;
	} in_item_t;

	typedef struct packed {
		logic [KIND_BITS-1:0]  kind;
		logic [TIME_BITS-1:0]  stamp_ns;
		logic [VALUE_BITS-1:0] value;
		logic                  last;
	} out_item_t;

	typedef struct packed {
		logic                 count_inc;
		logic                 latch;
		logic                 div_start;
		logic                 emit;
		logic [KIND_BITS-1:0] emit_kind;
		logic                 emit_last;
		logic                 commit;
	} pec_cmd_t;

	typedef struct packed {
		logic is_count;
		logic is_trunc;
		logic div_done;
		logic cnt_nz;
		logic skip_nz;
		logic out_free;
	} pec_status_t;

	function automatic logic [TIME_BITS-1:0] sat_add64(
		input logic [TIME_BITS-1:0] a,
		input logic [TIME_BITS-1:0] b
	);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
	endfunction

	function automatic logic [VALUE_BITS-1:0] sat32(input logic [TIME_BITS-1:0] v);
		return (v[TIME_BITS-1:VALUE_BITS] != '0) ? '1 : v[VALUE_BITS-1:0];
	endfunction

endpackage

// File: rtl/pec_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pec_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pec_div import pec_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [TIME_BITS-1:0]   dividend,
	input  logic [PERIOD_BITS-1:0] divisor,
	output logic                   done,
	output logic [TIME_BITS-1:0]   quot,
	output logic [PERIOD_BITS-1:0] rem
);

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [TIME_BITS-1:0]    quo_q;
	logic [PERIOD_BITS-1:0]  rem_q;
	logic [PERIOD_BITS:0]    trial;
	logic                    ge;

	assign trial = {rem_q, quo_q[TIME_BITS-1]};
	assign ge = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[TIME_BITS-2:0], ge};
			rem_q <= ge ? PERIOD_BITS'(trial - {1'b0, divisor}) : trial[PERIOD_BITS-1:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem = rem_q;

endmodule

// File: rtl/pec_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pec_datapath
// Period grid registers, event count, divider and the output register.
// ----------------------------------------------------------------------------
module pec_datapath import pec_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [TIME_BITS-1:0]      cfg_data,
	input  in_item_t                  in_item,
	input  logic                      out_stall,
	output logic                      out_valid,
	output out_item_t                 out_item,
	input  pec_cmd_t                  cmd,
	output pec_status_t               status
);

	logic [PERIOD_BITS-1:0] period_q;
	logic [TIME_BITS-1:0]   start_q;
	logic [TIME_BITS-1:0]   deadline_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic                   op_q;
	logic [TIME_BITS-1:0]   now_q;
	logic                   out_valid_q;
	out_item_t              out_item_q;

	logic [PERIOD_BITS-1:0] period_new;
	logic [TIME_BITS-1:0]   start_new;
	logic [PERIOD_BITS-1:0] eff_new;
	logic [TIME_BITS-1:0]   eff_p;
	logic                   div_done;
	logic [TIME_BITS-1:0]   quot;
	logic [PERIOD_BITS-1:0] rem;
	logic [VALUE_BITS-1:0]  count_val;
	logic [VALUE_BITS-1:0]  skip_val;
	logic                   cfg_hit;
	out_item_t              emit_item;

	assign eff_p = TIME_BITS'((period_q == '0) ? PERIOD_BITS'(1) : period_q);

	assign cfg_hit = cfg_we && (cfg_index == REG_PERIOD || cfg_index == REG_START);
	assign period_new = (cfg_index == REG_PERIOD) ? cfg_data[PERIOD_BITS-1:0] : period_q;
	assign start_new = (cfg_index == REG_START) ? cfg_data : start_q;
	assign eff_new = (period_new == '0) ? PERIOD_BITS'(1) : period_new;

	pec_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (in_item.timestamp_ns - deadline_q),
		.divisor  (eff_p[PERIOD_BITS-1:0]),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	assign count_val = sat32(TIME_BITS'(count_q));
	assign skip_val = (count_q != '0) ? sat32(quot) : sat32(sat_add64(quot, TIME_BITS'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			start_q <= START_RESET;
			deadline_q <= DEADLINE_RESET;
			count_q <= '0;
		end else if (cfg_hit) begin
			period_q <= period_new;
			start_q <= start_new;
			deadline_q <= sat_add64(start_new, TIME_BITS'(eff_new));
			count_q <= '0;
		end else if (cmd.count_inc) begin
			if (!(&count_q)) begin
				count_q <= count_q + 1'b1;
			end
		end else if (cmd.commit) begin
			if (!op_q) begin
				deadline_q <= sat_add64(now_q - TIME_BITS'(rem), eff_p);
				count_q <= COUNT_BITS'(1);
			end else begin
				deadline_q <= sat_add64(now_q, eff_p);
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= in_item.op;
			now_q <= in_item.timestamp_ns;
		end
	end

	always_comb begin
		emit_item.kind = cmd.emit_kind;
		emit_item.last = cmd.emit_last;
		case (cmd.emit_kind)
			KIND_FULL: begin
				emit_item.stamp_ns = deadline_q;
				emit_item.value = count_val;
			end
			KIND_TRUNC: begin
				emit_item.stamp_ns = now_q;
				emit_item.value = count_val;
			end
			default: begin
				emit_item.stamp_ns = '0;
				emit_item.value = skip_val;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_item_q <= emit_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	assign status.is_count = !in_item.op && (in_item.timestamp_ns <= deadline_q);
	assign status.is_trunc = in_item.op && (in_item.timestamp_ns < deadline_q);
	assign status.div_done = div_done;
	assign status.cnt_nz = count_q != '0;
	assign status.skip_nz = (count_q == '0) || (quot != '0);
	assign status.out_free = !out_valid_q || !out_stall;

endmodule

// File: rtl/pec_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pec_ctrl
// Sequencer for item acceptance, expiry division and result emission.
// ----------------------------------------------------------------------------
module pec_ctrl import pec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  pec_status_t status,
	output pec_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV = 3'd1;
	localparam logic [2:0] ST_EMIT_CNT = 3'd2;
	localparam logic [2:0] ST_EMIT_SKIP = 3'd3;
	localparam logic [2:0] ST_EMIT_TRUNC = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.emit_kind = KIND_FULL;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (status.is_count) begin
						cmd.count_inc = 1'b1;
					end else if (status.is_trunc) begin
						cmd.latch = 1'b1;
						state_d = ST_EMIT_TRUNC;
					end else begin
						cmd.latch = 1'b1;
						cmd.div_start = 1'b1;
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = status.cnt_nz ? ST_EMIT_CNT : ST_EMIT_SKIP;
				end
			end
			ST_EMIT_CNT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = KIND_FULL;
					cmd.emit_last = !status.skip_nz;
					if (status.skip_nz) begin
						state_d = ST_EMIT_SKIP;
					end else begin
						cmd.commit = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT_SKIP: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = KIND_SKIP;
					cmd.emit_last = 1'b1;
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_EMIT_TRUNC: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = KIND_TRUNC;
					cmd.emit_last = 1'b1;
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = state_q != ST_IDLE;

endmodule

// File: rtl/periodic_event_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_event_counter
// Counts events per period on a time grid and reports expired periods and truncating flushes.
// ----------------------------------------------------------------------------
// Input transactions (in_valid/in_stall, in_item) carry an op and a timestamp.
// Output transactions (out_valid/out_stall, out_item) carry the reports; the
// last report caused by an input has last set. Configuration writes on
// cfg_we/cfg_index/cfg_data set the period (index 0) or the start time
// (index 1) and re-arm the grid; other indexes are ignored.
// An event inside the current period gives no output, so such events are
// accepted back to back. A truncating flush latches the item and loads its
// report into the output register once that register is free. An expired
// period runs the 64-step bit-serial divider before its first report is
// loaded, and the block takes a new item right after the last report is
// loaded.
// The single output register is loaded while out_stall is low or it is empty;
// while the receiver stalls, pending reports wait and in_stall stays high.
// Reset arms the grid at time 0 with a period of one second and a zero count.
// ----------------------------------------------------------------------------
module periodic_event_counter import pec_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [TIME_BITS-1:0]      cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  in_item_t                  in_item,
	output logic                      out_valid,
	input  logic                      out_stall,
	output out_item_t                 out_item
);

	pec_cmd_t    cmd;
	pec_status_t status;

	pec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	pec_datapath #(
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_item  (out_item),
		.cmd       (cmd),
		.status    (status)
	);

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("Result loaded while the output register is still occupied.");

	a_commit_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (cmd.emit && cmd.emit_last))
		else $error("State committed without emitting the final result.");

	a_skip_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_kind == KIND_SKIP) |-> cmd.emit_last)
		else $error("Skipped-interval report not marked as the final result.");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> in_stall)
		else $error("Divider finished while the block accepts input.");

endmodule
